### hw/rtl/smp_pkg.sv
package smp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned KindW     = 3;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned HalfW     = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CountW    = 5;
  localparam int unsigned TdataOutW = 80;

  localparam logic [WordW-1:0] MagicCookie = 32'h2112_A442;

  localparam logic [HalfW-1:0] AttrUsername  = 16'h0006;
  localparam logic [HalfW-1:0] AttrPassword  = 16'h0007;
  localparam logic [HalfW-1:0] AttrIntegrity = 16'h0008;
  localparam logic [HalfW-1:0] AttrPriority  = 16'h0024;

  localparam logic [CountW-1:0] WordBytes   = 5'd4;
  localparam logic [CountW-1:0] HdrLastByte = 5'd19;
  localparam logic [CountW-1:0] FirstTidIdx = 5'd8;
  localparam logic [CountW-1:0] TypeLoIdx   = 5'd1;
  localparam logic [CountW-1:0] LenLoIdx    = 5'd3;
  localparam logic [CountW-1:0] CookieLoIdx = 5'd7;

  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ATTR_HDR = 3'd1,
    PH_BODY     = 3'd2,
    PH_PAD      = 3'd3,
    PH_DRAIN    = 3'd4
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_TID       = 3'd0,
    KIND_USERNAME  = 3'd1,
    KIND_PASSWORD  = 3'd2,
    KIND_INTEGRITY = 3'd3,
    KIND_PRIORITY  = 3'd4,
    KIND_END       = 3'd5
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_STUN  = 2'd1,
    ST_BAD_COOKY = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] data;
    logic [WordW-1:0] prio;
    status_e          status;
    logic [HalfW-1:0] msg_type;
    logic [HalfW-1:0] msg_length;
    logic             last;
  } res_t;

  // Up to two results per input byte: payload first, then end marker.
  typedef struct packed {
    logic pay_vld;
    res_t pay;
    logic end_vld;
    res_t fin;
  } push_t;

endpackage

### hw/rtl/smp_parser.sv
module smp_parser import smp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output push_t            push_o
);

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] bc_q, bc_d;
  logic [WordW-1:0]  shift_q, shift_d;
  logic [HalfW-1:0]  type_q, type_d;
  logic [HalfW-1:0]  len_q, len_d;
  logic [HalfW-1:0]  atype_q, atype_d;
  logic [HalfW-1:0]  arem_q, arem_d;
  logic [1:0]        pad_q, pad_d;
  logic [WordW-1:0]  prio_q, prio_d;
  status_e           err_q, err_d;

  logic [WordW-1:0]  shift_new;
  logic [CountW-1:0] bc_inc;
  logic [HalfW-1:0]  rem_dec;
  logic [WordW-1:0]  prio_new;
  status_e           status;
  res_t              pay;
  logic              pay_vld;
  res_t              fin;

  assign shift_new = {shift_q[WordW-ByteW-1:0], byte_i};
  assign bc_inc    = bc_q + 5'd1;
  assign rem_dec   = arem_q - 16'd1;
  assign prio_new  = {prio_q[WordW-ByteW-1:0], byte_i};

  always_comb begin
    phase_d = phase_q;
    bc_d    = bc_q;
    shift_d = shift_q;
    type_d  = type_q;
    len_d   = len_q;
    atype_d = atype_q;
    arem_d  = arem_q;
    pad_d   = pad_q;
    prio_d  = prio_q;
    err_d   = err_q;
    status  = ST_OK;
    pay     = '0;
    pay_vld = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        shift_d = shift_new;
        if (bc_q == '0 && byte_i[7:6] != 2'b00) begin
          err_d = ST_NOT_STUN;
        end
        if (bc_q == TypeLoIdx) begin
          type_d = shift_new[HalfW-1:0];
        end
        if (bc_q == LenLoIdx) begin
          len_d = shift_new[HalfW-1:0];
        end
        if (bc_q == CookieLoIdx && shift_new != MagicCookie && err_q == ST_OK) begin
          err_d = ST_BAD_COOKY;
        end
        if (bc_q >= FirstTidIdx && err_q == ST_OK) begin
          pay_vld  = 1'b1;
          pay.kind = KIND_TID;
          pay.data = byte_i;
        end
        if (bc_q == HdrLastByte) begin
          phase_d = (err_q != ST_OK) ? PH_DRAIN : PH_ATTR_HDR;
          bc_d    = '0;
          status  = err_q;
        end else begin
          bc_d   = bc_inc;
          status = ST_NOT_STUN;
        end
      end
      PH_ATTR_HDR: begin
        shift_d = shift_new;
        bc_d    = bc_inc;
        status  = ST_TRUNCATED;
        if (bc_inc >= WordBytes) begin
          atype_d = shift_new[WordW-1:HalfW];
          arem_d  = shift_new[HalfW-1:0];
          pad_d   = 2'd0 - shift_new[1:0];
          bc_d    = '0;
          prio_d  = '0;
          if (shift_new[HalfW-1:0] != '0) begin
            phase_d = PH_BODY;
          end else begin
            status = ST_OK;
          end
        end
      end
      PH_BODY: begin
        if (atype_q == AttrUsername) begin
          pay_vld  = 1'b1;
          pay.kind = KIND_USERNAME;
          pay.data = byte_i;
        end else if (atype_q == AttrPassword) begin
          pay_vld  = 1'b1;
          pay.kind = KIND_PASSWORD;
          pay.data = byte_i;
        end else if (atype_q == AttrIntegrity) begin
          pay_vld  = 1'b1;
          pay.kind = KIND_INTEGRITY;
          pay.data = byte_i;
        end else if (atype_q == AttrPriority && bc_q < WordBytes) begin
          prio_d = prio_new;
          bc_d   = bc_inc;
          if (bc_inc == WordBytes) begin
            pay_vld  = 1'b1;
            pay.kind = KIND_PRIORITY;
            pay.prio = prio_new;
          end
        end
        arem_d = rem_dec;
        status = ST_TRUNCATED;
        if (rem_dec == '0) begin
          bc_d = '0;
          if (pad_q != 2'd0) begin
            phase_d = PH_PAD;
          end else begin
            phase_d = PH_ATTR_HDR;
            status  = ST_OK;
          end
        end
      end
      PH_PAD: begin
        pad_d  = pad_q - 2'd1;
        status = ST_TRUNCATED;
        if (pad_q == 2'd1) begin
          phase_d = PH_ATTR_HDR;
          status  = ST_OK;
        end
      end
      default: begin
        status = err_q;
      end
    endcase

    fin            = '0;
    fin.kind       = KIND_END;
    fin.status     = status;
    fin.msg_type   = type_d;
    fin.msg_length = len_d;
    fin.last       = 1'b1;

    // end of message: everything back to the reset picture
    if (last_i) begin
      phase_d = PH_HEADER;
      bc_d    = '0;
      shift_d = '0;
      type_d  = '0;
      len_d   = '0;
      atype_d = '0;
      arem_d  = '0;
      pad_d   = '0;
      prio_d  = '0;
      err_d   = ST_OK;
    end
  end

  always_comb begin
    push_o.pay_vld = accept_i & pay_vld;
    push_o.pay     = pay;
    push_o.end_vld = accept_i & last_i;
    push_o.fin     = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      bc_q    <= '0;
      shift_q <= '0;
      type_q  <= '0;
      len_q   <= '0;
      atype_q <= '0;
      arem_q  <= '0;
      pad_q   <= '0;
      prio_q  <= '0;
      err_q   <= ST_OK;
    end else if (accept_i) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      shift_q <= shift_d;
      type_q  <= type_d;
      len_q   <= len_d;
      atype_q <= atype_d;
      arem_q  <= arem_d;
      pad_q   <= pad_d;
      prio_q  <= prio_d;
      err_q   <= err_d;
    end
  end

  a_drain_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DRAIN |-> err_q != ST_OK)
    else $error("drain phase without an error code");

  a_header_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> bc_q <= HdrLastByte)
    else $error("header byte count overran");

endmodule

### hw/rtl/smp_out_fifo.sv
module smp_out_fifo import smp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  res_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_p1;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      n_push;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_p1   = ptr_inc(wr_q);
  assign n_push  = {1'b0, push_i.pay_vld} + {1'b0, push_i.end_vld};
  assign pop     = valid_o & ready_i;
  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= RoomMax;
  assign res_o   = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    if (n_push == 2'd1) begin
      wr_d = wr_p1;
    end else if (n_push == 2'd2) begin
      wr_d = ptr_inc(wr_p1);
    end
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.pay_vld) begin
      mem_q[wr_q] <= push_i.pay;
    end
    if (push_i.end_vld) begin
      mem_q[push_i.pay_vld ? wr_p1 : wr_q] <= push_i.fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.pay_vld || push_i.end_vld) |-> cnt_q <= RoomMax)
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue count out of range");

endmodule

### hw/rtl/stun_message_parser.sv
// Channel   Dir  tdata (low bit first)                       tuser     tlast
// s_axis    in   in_byte[7:0]                                -         in_last
// m_axis    out  byte, priority, status, msg_type, msg_length out_kind  out_last
//
// One request (message byte) is taken per cycle while the result queue has
// room for two results; the parser state updates in that same cycle.
// Each byte gives zero, one or two results (payload, then end on the last
// byte); the results of a two-result byte leave one after the other through
// the single result port of the queue.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase
// and empties the queue. A stalled m_axis side fills the queue and drops
// s_axis_tready_o; no result is lost.
module stun_message_parser import smp_pkg::*; #(
  parameter int unsigned FifoDepth = 4  // result queue entries, at least 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request side
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [ByteW-1:0]     s_axis_tdata_i,   // [7:0] in_byte
  input  logic                 s_axis_tlast_i,   // in_last
  // result side
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] out_byte, [39:8] out_priority, [41:40] out_status,
  // [57:42] out_msg_type, [73:58] out_msg_length, [79:74] zero
  output logic [TdataOutW-1:0] m_axis_tdata_o,
  output logic [KindW-1:0]     m_axis_tuser_o,   // [2:0] out_kind
  output logic                 m_axis_tlast_o    // out_last
);

  logic  accept;
  push_t push;
  res_t  res;

  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  // Header check, attribute walk and result forming, all combinational on the accepted byte.
  smp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .push_o   (push)
  );

  // Registered result queue decouples the two sides.
  smp_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tdata_o = {6'b0, res.msg_length, res.msg_type, res.status,
                           res.prio, res.data};
  assign m_axis_tuser_o = res.kind;
  assign m_axis_tlast_o = res.last;

  a_end_carries_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == KIND_END)))
    else $error("end result and last flag disagree");

endmodule
